### rtl/core/qeb_pkg.sv
// qeb_pkg: shared types and constants of the quadrature encoder bank
package qeb_pkg;

  localparam int PhaseW   = 14;
  localparam int PhaseEnc = PhaseW / 2;
  localparam int NumW     = 3;
  localparam int ValW     = 7;
  localparam int CntW     = 8;
  localparam int CodeW    = 2;

  localparam logic [ValW-1:0] Center = 7'd64;
  localparam logic [CntW-1:0] CntMax = 8'h7F;
  localparam logic [CntW-1:0] CntMin = 8'h80;

  typedef struct packed {
    logic sample;
    logic capture;
    logic step;
  } qeb_cmd_t;

  typedef struct packed {
    logic hit;
    logic at_last;
    logic out_free;
  } qeb_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } qeb_state_t;

endpackage

### rtl/core/qeb_ctrl.sv
// qeb_ctrl: sequencer for sample and report words
module qeb_ctrl import qeb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_stall,
  input  qeb_sts_t sts,
  output qeb_cmd_t cmd
);

  qeb_state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.sample  = in_valid && !in_command;
        cmd.capture = in_valid && in_command;
        if (cmd.capture) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = !(sts.hit && !sts.out_free);
        if (cmd.step && sts.at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/qeb_datapath.sv
// qeb_datapath: per-encoder codes and counts, report walk and output register
module qeb_datapath import qeb_pkg::*; #(
  parameter int ENCODERS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qeb_cmd_t          cmd,
  output qeb_sts_t          sts,
  input  logic [PhaseW-1:0] in_phase_bits,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [NumW-1:0]   out_encoder_number,
  output logic [ValW-1:0]   out_change_value,
  output logic              out_last_of_run
);

  localparam int IW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

  logic [CodeW-1:0]  pair       [ENCODERS];
  logic [CodeW-1:0]  prev_r     [ENCODERS];
  logic [CodeW-1:0]  prev_nxt   [ENCODERS];
  logic [CntW-1:0]   count_r    [ENCODERS];
  logic [CntW-1:0]   count_nxt  [ENCODERS];
  logic [ENCODERS-1:0] mask_r, mask_nxt, mask_rest;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CntW-1:0]   sel_cnt;
  logic [IW+2:0]     idx_ext;
  logic              out_valid_r;
  logic [NumW-1:0]   num_r;
  logic [ValW-1:0]   val_r;
  logic              last_r;

  genvar g;
  for (g = 0; g < ENCODERS; g++) begin : g_lane
    if (g < PhaseEnc) begin : g_in
      assign pair[g] = in_phase_bits[2*g+1 -: 2];
    end else begin : g_zero
      assign pair[g] = '0;
    end
  end

  assign sel_cnt   = count_r[idx_r];
  assign idx_ext   = {3'b000, idx_r};
  assign mask_rest = mask_r & ~(ENCODERS'(1) << idx_r);

  assign sts.hit      = mask_r[idx_r];
  assign sts.at_last  = (idx_r == IW'(ENCODERS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] diff;
    for (int j = 0; j < ENCODERS; j++) begin
      code         = {pair[j][1], pair[j][1] ^ pair[j][0]};
      diff         = prev_r[j] - code;
      prev_nxt[j]  = prev_r[j];
      count_nxt[j] = count_r[j];
      mask_nxt[j]  = mask_r[j];
      if (cmd.sample && diff[0]) begin
        prev_nxt[j] = code;
        if (diff[1]) begin
          count_nxt[j] = (count_r[j] == CntMax) ? count_r[j] : count_r[j] + 8'd1;
        end else begin
          count_nxt[j] = (count_r[j] == CntMin) ? count_r[j] : count_r[j] - 8'd1;
        end
      end
      if (cmd.capture) begin
        mask_nxt[j] = (count_r[j][CntW-1:1] != '0);
      end
      if (cmd.step && idx_r == IW'(j)) begin
        count_nxt[j] = {{(CntW-1){1'b0}}, count_r[j][0]};
        mask_nxt[j]  = 1'b0;
      end
    end
    idx_nxt = idx_r;
    priority if (cmd.capture) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = sts.at_last ? '0 : idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < ENCODERS; j++) begin
        prev_r[j]  <= '0;
        count_r[j] <= '0;
      end
      mask_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int j = 0; j < ENCODERS; j++) begin
        prev_r[j]  <= prev_nxt[j];
        count_r[j] <= count_nxt[j];
      end
      mask_r <= mask_nxt;
      idx_r  <= idx_nxt;
      if (cmd.step && sts.hit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (cmd.step && sts.hit) begin
      num_r  <= idx_ext[NumW-1:0];
      val_r  <= Center + sel_cnt[CntW-1:1];
      last_r <= (mask_rest == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_encoder_number = num_r;
  assign out_change_value   = val_r;
  assign out_last_of_run    = last_r;

endmodule

### rtl/core/quadrature_encoder_bank_unit.sv
// quadrature_encoder_bank_unit: top level of the quadrature encoder bank
// a sample word updates every encoder in the cycle it is accepted, one word per cycle while no report walk runs
// a report word walks the encoders one per cycle, held only while a result word waits on
// a stalled output; each result word appears in the cycle after its step
// the single output register sets the pace once the receiver stalls
// synchronous active-low reset clears all codes, counts and the output valid
module quadrature_encoder_bank_unit import qeb_pkg::*; #(
  parameter int ENCODERS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [PhaseW-1:0] in_phase_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NumW-1:0]   out_encoder_number,
  output logic [ValW-1:0]   out_change_value,
  output logic              out_last_of_run
);

  qeb_cmd_t cmd;
  qeb_sts_t sts;

  qeb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  qeb_datapath #(
    .ENCODERS (ENCODERS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_phase_bits      (in_phase_bits),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_encoder_number (out_encoder_number),
    .out_change_value   (out_change_value),
    .out_last_of_run    (out_last_of_run)
  );

  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command) |=> in_stall)
    else $error("report word did not start the walk");

  a_sample_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_command) |=> !in_stall)
    else $error("sample word left the block busy");

  a_no_centre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_change_value != Center))
    else $error("result word reports no motion");

  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.hit) |-> sts.out_free)
    else $error("result word loaded over a stalled one");

endmodule
